// ===== design/itda_pkg.sv =====
// Package for the integer-to-ASCII converter: record types, the power-of-ten
// table and the character helpers used by the top level, the load stage, the digit cells and the serializer.
// Depends on nothing.
package itda_pkg;

    // Longest text is a sign and ten decimal digits.
    localparam int unsigned TEXT_LEN  = 11;
    localparam int unsigned NUM_CELLS = 10;

    // ASCII codes used by the formatter.
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_LC_A  = 7'h61;

    // Format select codes.
    localparam logic REQ_DEC = 1'b0;
    localparam logic REQ_HEX = 1'b1;

    // Left-aligned character buffer; entry 0 goes out first.
    typedef logic [TEXT_LEN-1:0][6:0] t_text;

    // Multiples 1..9 of one power of ten, wide enough for 9 * 10^9.
    typedef logic [9:1][33:0] t_mults;

    // Record that travels down the chain of digit cells.
    typedef struct packed {
        logic        hex;
        logic [31:0] mag;
        logic        started;
        logic [3:0]  cnt;
        t_text       text;
    } t_rec;

    // Power of ten for cell position pos; position 0 handles 10^9.
    function automatic logic [33:0] f_pow10(input logic [3:0] pos);
        logic [33:0] p;
        p = 34'd1;
        case (pos)
            4'd0:    p = 34'd1000000000;
            4'd1:    p = 34'd100000000;
            4'd2:    p = 34'd10000000;
            4'd3:    p = 34'd1000000;
            4'd4:    p = 34'd100000;
            4'd5:    p = 34'd10000;
            4'd6:    p = 34'd1000;
            4'd7:    p = 34'd100;
            4'd8:    p = 34'd10;
            default: p = 34'd1;
        endcase
        return p;
    endfunction

    // Constant multiples of the power of ten for one cell position.
    function automatic t_mults f_mults(input logic [3:0] pos);
        t_mults      m;
        logic [33:0] pw;
        pw = f_pow10(pos);
        for (int k = 1; k <= 9; k++) begin
            m[k] = pw * 34'(k);
        end
        return m;
    endfunction

    // Lower-case hex character for one nibble.
    function automatic logic [6:0] f_hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {3'b000, nib};
        end else begin
            c = CH_LC_A + {3'b000, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

// ===== design/itda_if.sv =====
// Handshake interfaces for the integer-to-ASCII converter channels.
// The input channel carries a format select and a word; the output carries one character.
// Depends on nothing.
interface itda_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink (input valid, input req_type, input value, output ready);
endinterface

interface itda_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

// ===== design/itda_load.sv =====
// Entry stage: registers a new word and sets up the record for the digit cells.
// Builds the whole hex text here; for decimal it takes the magnitude and the sign.
// Depends on itda_pkg.
module itda_load import itda_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rec        o_rec
);

    logic r_valid;
    t_rec r_rec;
    t_rec n_rec;
    logic w_take;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // Initial record: hex text complete, decimal sign placed and magnitude taken.
    always_comb begin
        n_rec         = '0;
        n_rec.hex     = (i_req_type == REQ_HEX);
        n_rec.started = 1'b0;
        for (int j = 0; j < TEXT_LEN; j++) begin
            n_rec.text[j] = CH_ZERO;
        end
        if (i_req_type == REQ_HEX) begin
            n_rec.mag     = i_value;
            n_rec.text[0] = CH_ZERO;
            n_rec.text[1] = CH_X;
            for (int j = 0; j < 8; j++) begin
                n_rec.text[j+2] = f_hex_char(i_value[31-4*j -: 4]);
            end
            n_rec.cnt = 4'd10;
        end else if (i_value[31]) begin
            n_rec.mag     = ~i_value + 32'd1;
            n_rec.text[0] = CH_MINUS;
            n_rec.cnt     = 4'd1;
        end else begin
            n_rec.mag = i_value;
            n_rec.cnt = 4'd0;
        end
    end

    // Stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rec <= n_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

// ===== design/itda_cell.sv =====
// Digit cell: takes one decimal digit off the magnitude for its power of ten
// and appends it to the text once the leading zeros are past.
// Depends on itda_pkg.
module itda_cell import itda_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_mults i_mults,
    input  logic   i_final,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_rec   i_rec,
    output logic   o_valid,
    input  logic   i_ready,
    output t_rec   o_rec
);

    logic        r_valid;
    t_rec        r_rec;
    t_rec        n_rec;
    logic [3:0]  w_digit;
    logic [33:0] w_sub;
    logic        w_emit;
    logic        w_take;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // Digit is the largest multiple that still fits under the magnitude.
    always_comb begin
        w_digit = 4'd0;
        w_sub   = '0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, i_rec.mag} >= i_mults[k]) begin
                w_digit = 4'(k);
                w_sub   = i_mults[k];
            end
        end
    end

    // In decimal mode the final cell always prints, which covers a zero word.
    assign w_emit = !i_rec.hex && ((w_digit != 4'd0) || i_rec.started || i_final);

    // Next record: remainder, and the digit appended at the fill position.
    always_comb begin
        n_rec = i_rec;
        if (!i_rec.hex) begin
            n_rec.mag = i_rec.mag - w_sub[31:0];
        end
        if (w_emit) begin
            n_rec.started = 1'b1;
            n_rec.cnt     = i_rec.cnt + 4'd1;
            for (int j = 0; j < TEXT_LEN; j++) begin
                if (i_rec.cnt == 4'(j)) begin
                    n_rec.text[j] = CH_ZERO + {3'b000, w_digit};
                end
            end
        end
    end

    // Cell valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Cell payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rec <= n_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

// ===== design/itda_ser.sv =====
// Serializer: holds a finished text and shifts it out one character per transaction.
// Takes the next text in the cycle its final character leaves.
// Depends on itda_pkg and itda_if.
module itda_ser import itda_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_rec  i_rec,
    itda_out_if.source o_out
);

    logic [3:0] r_left;
    t_text      r_text;
    logic       w_fire;
    logic       w_take;

    assign w_fire  = o_out.valid && o_out.ready;
    assign o_ready = (r_left == 4'd0) || ((r_left == 4'd1) && o_out.ready);
    assign w_take  = i_valid && o_ready;

    // Count of characters still to send.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 4'd0;
        end else if (w_take) begin
            r_left <= i_rec.cnt;
        end else if (w_fire) begin
            r_left <= r_left - 4'd1;
        end
    end

    // Character shift line; the head is always the character on offer.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_text <= i_rec.text;
        end else if (w_fire) begin
            for (int j = 0; j < TEXT_LEN - 1; j++) begin
                r_text[j] <= r_text[j+1];
            end
            r_text[TEXT_LEN-1] <= CH_ZERO;
        end
    end

    assign o_out.valid     = (r_left != 4'd0);
    assign o_out.character = r_text[0];
    assign o_out.last      = (r_left == 4'd1);

endmodule

// ===== design/int_to_decimal_or_hex_ascii.sv =====
// Channel   Dir  Payload                          Transaction
// i_in      in   req_type[0], value[31:0]         valid && ready
// o_out     out  character[6:0], last             valid && ready
//
// A word passes a load stage and ten digit cells (10^9 down to 10^0), one cell per cycle
// while the output does not stall the chain, and then enters the serializer.
// Each word then occupies the serializer until its characters are out: 1 to 11 in decimal,
// 10 in hex; the serializer sends one character per cycle while the output is ready.
// Synchronous active-low reset clears every valid flag and the character count.
// A stalled output holds the chain; each stage still takes a word whenever it is empty.
// Top level of the integer-to-ASCII converter. Depends on itda_pkg, itda_if,
// itda_load, itda_cell and itda_ser.
module int_to_decimal_or_hex_ascii import itda_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itda_in_if.sink   i_in,
    itda_out_if.source o_out
);

    logic w_valid [0:NUM_CELLS];
    logic w_ready [0:NUM_CELLS];
    t_rec w_rec   [0:NUM_CELLS];

    // Entry stage.
    itda_load u_load (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_req_type (i_in.req_type),
        .i_value    (i_in.value),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_rec      (w_rec[0])
    );

    // Row of digit cells, one per power of ten.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        itda_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_mults (f_mults(4'(g))),
            .i_final ((g == NUM_CELLS - 1) ? 1'b1 : 1'b0),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_rec   (w_rec[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_rec   (w_rec[g+1])
        );
    end

    // Character output.
    itda_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NUM_CELLS]),
        .o_ready (w_ready[NUM_CELLS]),
        .i_rec   (w_rec[NUM_CELLS]),
        .o_out   (o_out)
    );

endmodule

// ===== sim/int_to_decimal_or_hex_ascii_tb.sv =====
// Testbench for the integer-to-ASCII converter: drives words in decimal and hex mode,
// predicts the character text of each word and checks every output transaction in order.
// Depends on itda_pkg, itda_if and the int_to_decimal_or_hex_ascii top level.
module int_to_decimal_or_hex_ascii_tb import itda_pkg::*; ();

    // Generous bound on the whole run, in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Cycles to keep watching the output after the last expected character.
    localparam int unsigned TAIL_CYCLES = 40;

    // One expected output character.
    typedef struct {
        logic [6:0] ch;
        logic       last;
    } t_glyph;

    logic i_clk;
    logic i_rst_n;

    itda_in_if  in_ch ();
    itda_out_if out_ch ();

    int_to_decimal_or_hex_ascii dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Characters still owed by the block, oldest first.
    t_glyph      text_q[$];
    int unsigned words_sent;
    int unsigned chars_checked;
    int unsigned hex_words;
    int unsigned dec_words;
    int unsigned error_count;
    int unsigned cycle_count;

    // Idling controls set by the test tasks and read by the sender and the receiver.
    bit          tx_idle;
    bit          rx_idle;
    int unsigned rx_hold;

    string       nibble_chars = "0123456789abcdef";

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter and watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d characters still expected",
                 cycle_count, text_q.size());
        $display("Test completed with failures");
        $finish;
    end

    // Work out the text of one word and append it to the expected characters.
    function automatic void predict_text(input logic req, input logic [31:0] word);
        t_glyph      line[$];
        t_glyph      g;
        logic [31:0] mag;
        logic [31:0] pw;
        logic [31:0] digit;
        bit          started;
        g.last  = 1'b0;
        started = 1'b0;
        if (req == REQ_HEX) begin
            g.ch = CH_ZERO;
            line.push_back(g);
            g.ch = CH_X;
            line.push_back(g);
            for (int sh = 28; sh >= 0; sh -= 4) begin
                g.ch = 7'(nibble_chars[int'(word[sh +: 4])]);
                line.push_back(g);
            end
        end else if (word == 32'd0) begin
            g.ch = CH_ZERO;
            line.push_back(g);
        end else begin
            mag = word;
            // Negative words print a sign, then the unsigned magnitude.
            if (word[31]) begin
                mag  = ~word + 32'd1;
                g.ch = CH_MINUS;
                line.push_back(g);
            end
            for (pw = 32'd1000000000; pw != 32'd0; pw = pw / 32'd10) begin
                digit = mag / pw;
                if (digit != 32'd0 || started) begin
                    g.ch = CH_ZERO + digit[6:0];
                    line.push_back(g);
                    mag     = mag % pw;
                    started = 1'b1;
                end
            end
        end
        line[line.size() - 1].last = 1'b1;
        foreach (line[i]) text_q.push_back(line[i]);
    endfunction

    // Offer one word on the input channel and wait for its transaction.
    task automatic send_word(input logic req, input logic [31:0] word);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= req;
        in_ch.value    <= word;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_text(req, word);
        words_sent++;
        if (req == REQ_HEX) hex_words++;
        else dec_words++;
    endtask

    // Drop the input valid and wait until every expected character has come out.
    task automatic wait_drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (text_q.size() != 0) @(posedge i_clk);
    endtask

    // Random word with a spread of magnitudes and both signs.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(0, 6))
            0: w = $urandom_range(0, 99);
            1: w = -$urandom_range(1, 99);
            2: w = $urandom >> $urandom_range(0, 31);
            3: w = -($urandom >> $urandom_range(0, 31));
            4: begin
                // Near a power of ten, where digit counts change.
                w = 32'd1;
                repeat ($urandom_range(0, 9)) w = w * 32'd10;
                w = w + $urandom_range(0, 2) - 32'd1;
                if ($urandom_range(0, 1)) w = -w;
            end
            5: w = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                        : 32'h7fff_ffff - $urandom_range(0, 3);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Receiver: draws a stall for every character while idling is on and honors a requested long hold.
    initial begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = rx_idle ? $urandom_range(0, 19) : 0;
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    // Checker: compare every output transaction with the oldest expected character.
    always @(posedge i_clk) begin
        t_glyph want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (text_q.size() == 0) begin
                $error("unexpected character %0h (last %0b)", out_ch.character, out_ch.last);
                error_count++;
            end else begin
                want = text_q.pop_front();
                chars_checked++;
                if (out_ch.character !== want.ch) begin
                    $error("character mismatch: expected %0h, actual %0h",
                           want.ch, out_ch.character);
                    error_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b", want.last, out_ch.last);
                    error_count++;
                end
            end
        end
    end

    // Extremes of the word in both modes, zero, negatives and the most negative value.
    task automatic test_directed();
        logic [31:0] dec_vals[$];
        logic [31:0] hex_vals[$];
        dec_vals = '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, 32'd100,
                     32'd999999999, 32'd1000000000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h8000_0001, -32'd10, 32'd4000000000};
        hex_vals = '{32'd0, 32'hffff_ffff, 32'h8000_0000, 32'h0123_abcd,
                     32'hdead_beef, 32'ha5a5_a5a5, 32'h5a5a_5a5a};
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        foreach (dec_vals[i]) send_word(REQ_DEC, dec_vals[i]);
        foreach (hex_vals[i]) send_word(REQ_HEX, hex_vals[i]);
        wait_drain();
    endtask

    // Random words in both modes; idling on both sides switches between stretches.
    task automatic test_random_mix();
        for (int n = 0; n < 190; n++) begin
            if (n % 40 == 0) begin
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            send_word($urandom_range(0, 1) ? REQ_HEX : REQ_DEC, random_word());
            // Now and then the sender waits for the whole backlog to come out.
            if ($urandom_range(0, 29) == 0) wait_drain();
        end
        wait_drain();
    endtask

    // Words back to back with the receiver always ready.
    task automatic test_back_to_back();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int n = 0; n < 30; n++) begin
            send_word($urandom_range(0, 1) ? REQ_HEX : REQ_DEC, random_word());
        end
        wait_drain();
    endtask

    // Receiver holds off long enough that the block fills and stalls its input.
    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = 400;
        for (int n = 0; n < 25; n++) begin
            send_word($urandom_range(0, 1) ? REQ_HEX : REQ_DEC, random_word());
        end
        wait_drain();
        rx_idle = 1'b1;
        tx_idle = 1'b1;
    endtask

    // Test sequence.
    initial begin
        in_ch.valid    = 1'b0;
        in_ch.req_type = REQ_DEC;
        in_ch.value    = 32'd0;
        i_rst_n        = 1'b0;
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        rx_hold        = 0;
        words_sent     = 0;
        chars_checked  = 0;
        hex_words      = 0;
        dec_words      = 0;
        error_count    = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_mix();
        test_back_to_back();
        test_output_backpressure();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Converted %0d words (%0d decimal, %0d hex) and checked %0d characters,",
                 words_sent, dec_words, hex_words, chars_checked);
        $display("with random stalls, back-to-back traffic and a long output hold.");
        if (error_count == 0 && text_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
